[hdl/button_debounce_encoder_delta_core_assert.svh]
// ----------------------------------------------------------------------------
// button_debounce_encoder_delta_core_assert
// Assertion macros used by the verification-only checker file.
// Each macro checks a same-cycle or next-cycle implication on the rising edge.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_ENCODER_DELTA_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_ENCODER_DELTA_CORE_ASSERT_SVH

// ante and cons hold in the same cycle
`define BDE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante now, cons in the next cycle
`define BDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bde_pkg.sv]
// ----------------------------------------------------------------------------
// bde_pkg
// Types and constants for the button debounce / encoder delta block.
// ----------------------------------------------------------------------------
package bde_pkg;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [15:0] DebounceMsReset = 16'd50;

  typedef enum logic [2:0] {
    OP_SAMPLE         = 3'd0,
    OP_TAKE_PRESSED   = 3'd1,
    OP_TAKE_RELEASED  = 3'd2,
    OP_CLEAR_FLAGS    = 3'd3,
    OP_RESET_POSITION = 3'd4
  } op_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_DIRECTION_REVERSED = 2'd0,
    CFG_BUTTON_ACTIVE_LOW  = 2'd1,
    CFG_DEBOUNCE_MS        = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    op_e                op;
    logic [31:0]        now_ms;
    logic               pin_level;
    logic signed [31:0] encoder_count;
  } req_t;

  typedef struct packed {
    logic               button_down;
    logic               pressed_pending;
    logic               released_pending;
    logic               taken_flag;
    logic               new_input;
    logic signed [31:0] encoder_delta;
    logic               delta_event;
    logic               button_event;
  } rsp_t;

  typedef struct packed {
    logic        direction_reversed;
    logic        button_active_low;
    logic [15:0] debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic        last_raw_level;
    logic        debounced_state;
    logic        pressed_flag;
    logic        released_flag;
    logic        new_input_flag;
    logic [31:0] last_change_time;
    logic [31:0] last_position;
    logic [31:0] delta_latch;
  } state_t;

endpackage

[hdl/bde_cfg.sv]
// ----------------------------------------------------------------------------
// bde_cfg
// Configuration register file, write-only.
// ----------------------------------------------------------------------------
module bde_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bde_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [bde_pkg::CfgDataW-1:0]    cfg_data,
  output bde_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction_reversed <= 1'b0;
      cfg.button_active_low  <= 1'b1;
      cfg.debounce_ms        <= bde_pkg::DebounceMsReset;
    end else if (cfg_we) begin
      case (cfg_index)
        bde_pkg::CFG_DIRECTION_REVERSED: cfg.direction_reversed <= cfg_data[0];
        bde_pkg::CFG_BUTTON_ACTIVE_LOW:  cfg.button_active_low  <= cfg_data[0];
        bde_pkg::CFG_DEBOUNCE_MS:        cfg.debounce_ms        <= cfg_data[15:0];
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

endmodule

[hdl/bde_step.sv]
// ----------------------------------------------------------------------------
// bde_step
// Next-state and result logic for one request.
// ----------------------------------------------------------------------------
module bde_step (
  input  bde_pkg::req_t   req,
  input  bde_pkg::cfg_t   cfg,
  input  bde_pkg::state_t st,
  output bde_pkg::state_t st_next,
  output bde_pkg::rsp_t   rsp
);

  logic [31:0] count;
  logic [31:0] pos;
  logic [31:0] diff;
  logic        level;
  logic        level_changed;
  logic [31:0] elapsed;
  logic        stable;
  logic        taken;
  logic        delta_ev;
  logic        button_ev;

  assign count         = req.encoder_count;
  assign pos           = cfg.direction_reversed ? (32'd0 - count) : count;
  assign diff          = pos - st.last_position;
  assign level         = req.pin_level ^ cfg.button_active_low;
  assign level_changed = level != st.last_raw_level;
  // a fresh edge restarts the timer, so elapsed is zero then
  assign elapsed       = level_changed ? 32'd0 : (req.now_ms - st.last_change_time);
  assign stable        = elapsed > {16'd0, cfg.debounce_ms};

  always_comb begin
    st_next   = st;
    taken     = 1'b0;
    delta_ev  = 1'b0;
    button_ev = 1'b0;
    case (req.op)
      bde_pkg::OP_SAMPLE: begin
        if (diff != 32'd0) begin
          st_next.delta_latch    = diff;
          st_next.last_position  = pos;
          st_next.new_input_flag = 1'b1;
          delta_ev               = 1'b1;
        end
        if (level_changed) begin
          st_next.last_change_time = req.now_ms;
        end
        if (stable && (level != st.debounced_state)) begin
          st_next.debounced_state = level;
          st_next.new_input_flag  = 1'b1;
          if (level) begin
            st_next.pressed_flag = 1'b1;
          end else begin
            st_next.released_flag = 1'b1;
          end
          button_ev = 1'b1;
        end
        st_next.last_raw_level = level;
      end
      bde_pkg::OP_TAKE_PRESSED: begin
        taken                = st.pressed_flag;
        st_next.pressed_flag = 1'b0;
      end
      bde_pkg::OP_TAKE_RELEASED: begin
        taken                 = st.released_flag;
        st_next.released_flag = 1'b0;
      end
      bde_pkg::OP_CLEAR_FLAGS: begin
        st_next.new_input_flag = 1'b0;
        st_next.pressed_flag   = 1'b0;
        st_next.released_flag  = 1'b0;
        st_next.delta_latch    = 32'd0;
      end
      bde_pkg::OP_RESET_POSITION: begin
        st_next.last_position = 32'd0;
        st_next.delta_latch   = 32'd0;
      end
      default: begin
        // unused op: state unchanged
      end
    endcase
  end

  always_comb begin
    rsp.button_down      = st_next.debounced_state;
    rsp.pressed_pending  = st_next.pressed_flag;
    rsp.released_pending = st_next.released_flag;
    rsp.taken_flag       = taken;
    rsp.new_input        = st_next.new_input_flag;
    rsp.encoder_delta    = st_next.delta_latch;
    rsp.delta_event      = delta_ev;
    rsp.button_event     = button_ev;
  end

endmodule

[hdl/button_debounce_encoder_delta_core.sv]
// ----------------------------------------------------------------------------
// button_debounce_encoder_delta_core
// Push-button debouncer with quadrature encoder delta tracking.
//
// Every request carries an op, a millisecond timestamp, the raw pin level and
// the external counter value, and yields exactly one response. A sample op
// latches any nonzero encoder change as the delta and debounces the button:
// the level must hold strictly longer than debounce_ms before it becomes the
// debounced state and raises the sticky pressed or released flag. The other
// ops read-and-clear a flag, clear all flags and the delta, or zero the
// position and the delta. While no stall holds the flow, one request is
// taken every clock; each request passes the request register and then the
// response register, where its response is offered, with the state update
// done in one pass of logic between them, so a request sees the state left
// by the one right before it. A stalled response holds in the response
// register while the request register still takes one more request; only
// when both are full does stall reach the request side.
// Configuration is write-only, applied at the edge of the write, and meant to
// change only while no request is in flight.
// ----------------------------------------------------------------------------
module button_debounce_encoder_delta_core (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           req_valid,
  output logic                           req_stall,
  input  bde_pkg::req_t                  req,
  // response channel
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output bde_pkg::rsp_t                  rsp,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [bde_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [bde_pkg::CfgDataW-1:0]   cfg_data
);

  bde_pkg::cfg_t   cfg;
  bde_pkg::state_t st;
  bde_pkg::state_t st_next;
  bde_pkg::req_t   req_q;
  logic            req_q_valid;
  bde_pkg::rsp_t   rsp_next;
  logic            accept;
  logic            advance;

  bde_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  bde_step u_step (
    .req    (req_q),
    .cfg    (cfg),
    .st     (st),
    .st_next(st_next),
    .rsp    (rsp_next)
  );

  // The held request moves on when the response register is empty or draining.
  assign advance   = req_q_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = req_q_valid && !advance;
  assign accept    = req_valid && !req_stall;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else begin
      req_q_valid <= accept || req_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
  end

  // block state, committed as the request moves to the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

endmodule

[hdl/bde_checker.sv]
// ----------------------------------------------------------------------------
// bde_checker
// Port-level checks for the debounce / encoder delta core.
// ----------------------------------------------------------------------------
`include "button_debounce_encoder_delta_core_assert.svh"

module bde_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input bde_pkg::rsp_t rsp
);

  logic rsp_held;
  logic button_seen;
  logic button_ok;
  logic delta_seen;
  logic delta_ok;
  logic take_seen;
  logic take_ok;

  assign rsp_held    = rsp_valid && rsp_stall;
  assign button_seen = rsp_valid && rsp.button_event;
  assign button_ok   = rsp.new_input &&
                       (rsp.button_down ? rsp.pressed_pending : rsp.released_pending);
  assign delta_seen  = rsp_valid && rsp.delta_event;
  assign delta_ok    = rsp.new_input && (rsp.encoder_delta != 32'sd0);
  assign take_seen   = rsp_valid && rsp.taken_flag;
  assign take_ok     = !rsp.delta_event && !rsp.button_event;

  `BDE_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_held, rsp_valid && $stable(rsp), "rsp changed")
  `BDE_ASSERT_NOW(a_no_stall_when_empty, clk, rst, !rsp_valid, !req_stall, "stall while empty")
  `BDE_ASSERT_NOW(a_button_flag, clk, rst, button_seen, button_ok, "button event without flags")
  `BDE_ASSERT_NOW(a_delta_nonzero, clk, rst, delta_seen, delta_ok, "zero delta on event")
  `BDE_ASSERT_NOW(a_take_exclusive, clk, rst, take_seen, take_ok, "take with sample events")

endmodule

bind button_debounce_encoder_delta_core bde_checker u_bde_checker (
  .clk      (clk),
  .rst      (rst),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);
